// ===== hdl/isc_pkg.sv =====
// isc_pkg: types, class codes, reset values and the byte swap helper
// for the ip-id sequence classifier; no dependencies
`default_nettype none

package isc_pkg;

   localparam int unsigned ID_W   = 16;
   localparam int unsigned MIN_W  = ID_W + 1;
   localparam int unsigned SUM_W  = 32;

   // minimum trackers start above any 16-bit step
   localparam logic [MIN_W-1:0] STEP_MIN_RESET = 17'h1FFFF;

   typedef enum logic [2:0] {
      CLASS_UNKNOWN = 3'd0,
      CLASS_ZERO    = 3'd1,
      CLASS_CONST   = 3'd2,
      CLASS_ECHO    = 3'd3,
      CLASS_INCR    = 3'd4
   } class_type;

   typedef struct packed {
      logic [ID_W-1:0] probe_id;
      logic [ID_W-1:0] reply_id;
      logic            reply_ok;
      logic            last;
   } beat_type;

   typedef struct packed {
      class_type       class_code;
      logic [ID_W-1:0] min_step;
      logic [ID_W-1:0] max_step;
   } result_type;

   typedef struct packed {
      logic             started;
      logic             failed;
      logic [ID_W-1:0]  prev_id;
      logic             first_was_zero;
      logic             echo_flag;
      logic             const_flag;
      logic [MIN_W-1:0] native_min;
      logic [ID_W-1:0]  native_max;
      logic [MIN_W-1:0] swapped_min;
      logic [ID_W-1:0]  swapped_max;
      logic [SUM_W-1:0] native_sum;
      logic [SUM_W-1:0] swapped_sum;
   } run_state_type;

   localparam run_state_type RUN_RESET = '{
      started:        1'b0,
      failed:         1'b0,
      prev_id:        '0,
      first_was_zero: 1'b0,
      echo_flag:      1'b1,
      const_flag:     1'b1,
      native_min:     STEP_MIN_RESET,
      native_max:     '0,
      swapped_min:    STEP_MIN_RESET,
      swapped_max:    '0,
      native_sum:     '0,
      swapped_sum:    '0
   };

   function automatic logic [ID_W-1:0] swap16(input logic [ID_W-1:0] x);
      return {x[7:0], x[15:8]};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/isc_req_if.sv =====
// isc_req_if: valid/ready channel carrying one probe/reply beat
// depends on isc_pkg for the id width
`default_nettype none

interface isc_req_if;
   logic                      valid;
   logic                      ready;
   logic [isc_pkg::ID_W-1:0]  probe_id;
   logic [isc_pkg::ID_W-1:0]  reply_id;
   logic                      reply_ok;
   logic                      last;

   modport source (output valid, output probe_id, output reply_id,
                   output reply_ok, output last, input ready);
   modport sink   (input valid, input probe_id, input reply_id,
                   input reply_ok, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/isc_rsp_if.sv =====
// isc_rsp_if: valid/ready channel carrying one classification beat
// depends on isc_pkg for the class type and id width
`default_nettype none

interface isc_rsp_if;
   logic                      valid;
   logic                      ready;
   isc_pkg::class_type        class_code;
   logic [isc_pkg::ID_W-1:0]  min_step;
   logic [isc_pkg::ID_W-1:0]  max_step;

   modport source (output valid, output class_code, output min_step,
                   output max_step, input ready);
   modport sink   (input valid, input class_code, input min_step,
                   input max_step, output ready);
endinterface

`default_nettype wire

// ===== hdl/isc_track.sv =====
// isc_track: per-run state registers, step update and end-of-run classification
// depends on isc_pkg
`default_nettype none

module isc_track (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire isc_pkg::beat_type   beat,
   output isc_pkg::result_type      result
);

   isc_pkg::run_state_type state_ff;
   isc_pkg::run_state_type state_in;
   isc_pkg::run_state_type upd;
   logic [isc_pkg::ID_W-1:0] d_nat;
   logic [isc_pkg::ID_W-1:0] d_swp;
   logic [isc_pkg::ID_W-1:0] reply_swp;

   assign reply_swp = isc_pkg::swap16(beat.reply_id);
   assign d_nat     = beat.reply_id - state_ff.prev_id;
   assign d_swp     = reply_swp - isc_pkg::swap16(state_ff.prev_id);

   always_comb begin
      upd = state_ff;
      if (!beat.reply_ok) begin
         upd.failed = 1'b1;
      end else if (!state_ff.failed) begin
         if (!state_ff.started) begin
            upd.prev_id        = beat.reply_id;
            upd.first_was_zero = (beat.reply_id == '0);
         end else begin
            if ({1'b0, d_nat} < state_ff.native_min) begin
               upd.native_min = {1'b0, d_nat};
            end
            if (d_nat > state_ff.native_max) begin
               upd.native_max = d_nat;
            end
            upd.native_sum = state_ff.native_sum
                           + {{(isc_pkg::SUM_W-isc_pkg::ID_W){1'b0}}, d_nat};
            if ({1'b0, d_swp} < state_ff.swapped_min) begin
               upd.swapped_min = {1'b0, d_swp};
            end
            if (d_swp > state_ff.swapped_max) begin
               upd.swapped_max = d_swp;
            end
            upd.swapped_sum = state_ff.swapped_sum
                            + {{(isc_pkg::SUM_W-isc_pkg::ID_W){1'b0}}, d_swp};
            // echo test wins; constant test skipped on the item that clears echo
            if (state_ff.echo_flag && (beat.probe_id != beat.reply_id)
                && (beat.probe_id != reply_swp)) begin
               upd.echo_flag = 1'b0;
            end else if (state_ff.const_flag
                         && (state_ff.prev_id != beat.reply_id)) begin
               upd.const_flag = 1'b0;
            end
            upd.prev_id = beat.reply_id;
         end
      end
      upd.started = 1'b1;
   end

   // classification from the updated state
   always_comb begin
      result = '{class_code: isc_pkg::CLASS_UNKNOWN, min_step: '0, max_step: '0};
      if (!upd.failed) begin
         if (!upd.const_flag && !upd.echo_flag) begin
            result.class_code = isc_pkg::CLASS_INCR;
            if (upd.native_sum < upd.swapped_sum) begin
               result.min_step = upd.native_min[isc_pkg::ID_W-1:0];
               result.max_step = upd.native_max;
            end else begin
               result.min_step = upd.swapped_min[isc_pkg::ID_W-1:0];
               result.max_step = upd.swapped_max;
            end
         end else if (upd.const_flag) begin
            result.class_code = upd.first_was_zero ? isc_pkg::CLASS_ZERO
                                                   : isc_pkg::CLASS_CONST;
         end else begin
            result.class_code = isc_pkg::CLASS_ECHO;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (step_en) begin
         state_in = beat.last ? isc_pkg::RUN_RESET : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isc_pkg::RUN_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_sums_clear_before_start: assert property (@(posedge clock) disable iff (reset)
      !state_ff.started |-> (state_ff.native_sum == '0 && state_ff.swapped_sum == '0))
      else $error("step sums nonzero before run start");

   a_native_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff.native_min != isc_pkg::STEP_MIN_RESET)
      |-> (state_ff.native_min[isc_pkg::ID_W-1:0] <= state_ff.native_max))
      else $error("native step minimum above maximum");

   a_run_clears_after_last: assert property (@(posedge clock) disable iff (reset)
      (step_en && beat.last) |=> (state_ff == isc_pkg::RUN_RESET))
      else $error("run state not cleared after last beat");
`endif

endmodule

`default_nettype wire

// ===== hdl/ipid_sequence_classifier.sv =====
// ipid_sequence_classifier: top level with input register, run tracker and
// result register; depends on isc_pkg, isc_req_if, isc_rsp_if, isc_track
`default_nettype none

// Classifies a run of probe/reply ip-id pairs. Each req beat carries one pair,
// a reply_ok flag (exactly one reply seen) and a last mark. The block keeps the
// previous reply id and, for native and byte-swapped order, the min, max and
// sum of the 16-bit wrapped steps between consecutive replies. The beat with
// last set yields one rsp beat: class unknown (any beat lacked a good reply),
// zero, constant, echo or incrementing; for incrementing runs min_step and
// max_step come from the byte order with the smaller step sum (byte-swapped
// on a tie), otherwise they are 0. Beats without last yield nothing. Throughput
// is one beat per clock while no last beat is held back. An accepted beat lands
// in the input register and goes through the step/classify logic into the
// result register, which drives rsp valid.
// A last beat waits in the input register only while an earlier result is
// still held in the result register and rsp.ready is low.
module ipid_sequence_classifier (
   input  wire logic  clock,
   input  wire logic  reset,
   isc_req_if.sink    req_bus,
   isc_rsp_if.source  rsp_bus
);

   // input register
   isc_pkg::beat_type   beat_ff;
   isc_pkg::beat_type   beat_in;
   logic                beat_valid_ff;
   logic                beat_valid_in;

   // result register
   isc_pkg::result_type rsp_data_ff;
   isc_pkg::result_type rsp_data_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   isc_pkg::result_type result;
   logic                req_accept;
   logic                step_en;

   // a held beat moves on unless it is a last beat and the result slot is busy
   assign step_en    = beat_valid_ff
                       && (!beat_ff.last || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !beat_valid_ff || step_en;
   assign req_accept = req_bus.valid && req_bus.ready;

   always_comb begin
      beat_in       = beat_ff;
      beat_valid_in = beat_valid_ff;
      if (req_accept) begin
         beat_in       = '{probe_id: req_bus.probe_id, reply_id: req_bus.reply_id,
                           reply_ok: req_bus.reply_ok, last: req_bus.last};
         beat_valid_in = 1'b1;
      end else if (step_en) begin
         beat_valid_in = 1'b0;
      end
   end

   isc_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .beat    (beat_ff),
      .result  (result)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step_en && beat_ff.last) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         beat_valid_ff <= beat_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      beat_ff     <= beat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.class_code = rsp_data_ff.class_code;
   assign rsp_bus.min_step   = rsp_data_ff.min_step;
   assign rsp_bus.max_step   = rsp_data_ff.max_step;

`ifndef SYNTH
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(beat_valid_ff && beat_ff.last))
      else $error("result beat without a last input beat");

   a_stall_only_when_holding: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (beat_valid_ff && beat_ff.last && rsp_valid_ff))
      else $error("input stalled without a held last beat");

   a_steps_zero_unless_incr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.class_code != isc_pkg::CLASS_INCR)
      |-> (rsp_data_ff.min_step == '0 && rsp_data_ff.max_step == '0))
      else $error("step fields set on non-incrementing class");
`endif

endmodule

`default_nettype wire

// ===== verif/isc_class_checker.sv =====
// isc_class_checker: watches the req and rsp channels of the ip-id sequence
// classifier, predicts each run's classification and compares rsp beats
// depends on isc_pkg, isc_req_if and isc_rsp_if
`timescale 1ns / 100ps
`default_nettype none

module isc_class_checker (
   input  wire logic clock,
   input  wire logic reset,
   isc_req_if        req_mon,
   isc_rsp_if        rsp_mon,
   output int        fail_count,
   output int        verdicts_pending
);

   // running picture of the current run
   logic             run_open;
   logic             run_bad;
   logic             first_zero;
   logic             echo_ok;
   logic             const_ok;
   logic [15:0]      last_reply;
   logic [16:0]      nat_lo;
   logic [16:0]      swp_lo;
   logic [15:0]      nat_hi;
   logic [15:0]      swp_hi;
   logic [31:0]      nat_total;
   logic [31:0]      swp_total;

   isc_pkg::result_type verdict_queue[$];

   function automatic void clear_run();
      run_open   = 1'b0;
      run_bad    = 1'b0;
      first_zero = 1'b0;
      echo_ok    = 1'b1;
      const_ok   = 1'b1;
      last_reply = '0;
      nat_lo     = 17'h1FFFF;
      swp_lo     = 17'h1FFFF;
      nat_hi     = '0;
      swp_hi     = '0;
      nat_total  = '0;
      swp_total  = '0;
   endfunction

   // fold one accepted beat into the run; a last beat queues the verdict
   function automatic void absorb_beat(input logic [15:0] probe, input logic [15:0] reply,
                                       input logic ok, input logic fin);
      logic [15:0] nstep;
      logic [15:0] sstep;
      isc_pkg::result_type verdict;
      if (!ok) begin
         run_bad = 1'b1;
      end else if (!run_bad) begin
         if (!run_open) begin
            last_reply = reply;
            first_zero = (reply == 16'd0);
         end else begin
            nstep = reply - last_reply;
            sstep = {reply[7:0], reply[15:8]} - {last_reply[7:0], last_reply[15:8]};
            if ({1'b0, nstep} < nat_lo) nat_lo = {1'b0, nstep};
            if (nstep > nat_hi) nat_hi = nstep;
            nat_total = nat_total + {16'd0, nstep};
            if ({1'b0, sstep} < swp_lo) swp_lo = {1'b0, sstep};
            if (sstep > swp_hi) swp_hi = sstep;
            swp_total = swp_total + {16'd0, sstep};
            // a beat that breaks the echo skips the constant test
            if (echo_ok && probe != reply && probe != {reply[7:0], reply[15:8]})
               echo_ok = 1'b0;
            else if (const_ok && last_reply != reply)
               const_ok = 1'b0;
            last_reply = reply;
         end
      end
      run_open = 1'b1;
      if (fin) begin
         verdict.class_code = isc_pkg::CLASS_UNKNOWN;
         verdict.min_step   = '0;
         verdict.max_step   = '0;
         if (!run_bad) begin
            if (!const_ok && !echo_ok) begin
               verdict.class_code = isc_pkg::CLASS_INCR;
               if (nat_total < swp_total) begin
                  verdict.min_step = nat_lo[15:0];
                  verdict.max_step = nat_hi;
               end else begin
                  verdict.min_step = swp_lo[15:0];
                  verdict.max_step = swp_hi;
               end
            end else if (const_ok) begin
               verdict.class_code = first_zero ? isc_pkg::CLASS_ZERO
                                               : isc_pkg::CLASS_CONST;
            end else begin
               verdict.class_code = isc_pkg::CLASS_ECHO;
            end
         end
         verdict_queue.push_back(verdict);
         clear_run();
      end
   endfunction

   always @(posedge clock) begin
      isc_pkg::result_type want;
      if (reset) begin
         clear_run();
         verdict_queue.delete();
         fail_count = 0;
      end else begin
         // rsp first: a req beat of this edge cannot answer at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_queue.size() == 0) begin
               $error("unexpected rsp beat: class_code %0d min_step %0h max_step %0h",
                      rsp_mon.class_code, rsp_mon.min_step, rsp_mon.max_step);
               fail_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_mon.class_code !== want.class_code) begin
                  $error("class_code: expected %0d, got %0d",
                         want.class_code, rsp_mon.class_code);
                  fail_count++;
               end
               if (rsp_mon.min_step !== want.min_step) begin
                  $error("min_step: expected %0h, got %0h", want.min_step, rsp_mon.min_step);
                  fail_count++;
               end
               if (rsp_mon.max_step !== want.max_step) begin
                  $error("max_step: expected %0h, got %0h", want.max_step, rsp_mon.max_step);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_beat(req_mon.probe_id, req_mon.reply_id, req_mon.reply_ok, req_mon.last);
      end
      verdicts_pending = verdict_queue.size();
   end

endmodule

`default_nettype wire

// ===== verif/ipid_sequence_classifier_test.sv =====
// ipid_sequence_classifier_test: stimulus, clock, reset and verdict for the
// ip-id sequence classifier; depends on isc_pkg, both channel interfaces,
// the block itself and isc_class_checker
`timescale 1ns / 100ps
`default_nettype none

module ipid_sequence_classifier_test;

   // beat target for the random part, counted over every accepted beat
   localparam int ITEM_TARGET    = 1950;
   // cycles without any accepted beat before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // length of the long receiver hold-off that backs up the block
   localparam int HOLD_CYCLES    = 250;
   // settle time after the last verdict
   localparam int DRAIN_CYCLES   = 8;

   typedef enum int {
      RUN_NATIVE_UP,
      RUN_SWAP_UP,
      RUN_ECHO,
      RUN_CONST,
      RUN_ZERO,
      RUN_BROKEN,
      RUN_NOISE
   } run_kind_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_CHOKED,
      RX_TOGGLE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   fail_count;
   int   verdicts_pending;
   int   sent_beats   = 0;
   int   burst_left   = 0;
   int   idle_cycles  = 0;
   logic pressure_go  = 1'b0;

   isc_req_if req_bus ();
   isc_rsp_if rsp_bus ();

   ipid_sequence_classifier uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   isc_class_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hang detection: any accepted beat on either channel restarts the count
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver: open during the directed part, then one long hold-off while
   // the sender keeps pushing, then stretches of assorted stall patterns
   initial begin
      rx_mode_type mode;
      int          stretch;
      int          n;
      rsp_bus.ready = 1'b1;
      wait (pressure_go);
      @(negedge clock);
      rsp_bus.ready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clock);
      forever begin
         mode    = rx_mode_type'($urandom_range(0, 3));
         stretch = $urandom_range(5, 60);
         for (n = 0; n < stretch; n++) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_CHOKED: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_bus.ready <= n[0];
            endcase
         end
      end
   end

   // one req beat, offered at a falling edge and held until accepted;
   // bursts end in a gap with valid low so valid never drops and
   // rises within the same step
   task automatic send_beat(input logic [15:0] probe, input logic [15:0] reply,
                            input logic ok, input logic fin);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         // an occasional long burst gives stretches with no sender idling
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      req_bus.valid    <= 1'b1;
      req_bus.probe_id <= probe;
      req_bus.reply_id <= reply;
      req_bus.reply_ok <= ok;
      req_bus.last     <= fin;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
      sent_beats++;
   endtask

   // one run of a randomly chosen shape; most runs are well formed so the
   // step, echo and constant tracking all get exercised
   task automatic random_run();
      run_kind_type kind;
      int           pick;
      int           len;
      int           bad_at;
      int           k;
      logic [15:0]  probe;
      logic [15:0]  reply;
      logic [15:0]  swapped;
      logic [15:0]  step;
      logic         ok;
      logic         fin;
      pick = $urandom_range(0, 99);
      if (pick < 25)      kind = RUN_NATIVE_UP;
      else if (pick < 50) kind = RUN_SWAP_UP;
      else if (pick < 62) kind = RUN_ECHO;
      else if (pick < 72) kind = RUN_CONST;
      else if (pick < 80) kind = RUN_ZERO;
      else if (pick < 90) kind = RUN_BROKEN;
      else                kind = RUN_NOISE;
      // mostly short runs, now and then a long one
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      bad_at  = $urandom_range(0, len - 1);
      reply   = 16'($urandom_range(0, 16'hFFFF));
      swapped = reply;
      for (k = 0; k < len; k++) begin
         probe = 16'($urandom_range(0, 16'hFFFF));
         // small steps dominate, full-range ones cover the wrap
         step  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                             : 16'($urandom_range(1, 300));
         case (kind)
            RUN_NATIVE_UP, RUN_BROKEN: if (k > 0) reply = reply + step;
            RUN_SWAP_UP: begin
               if (k > 0) swapped = swapped + step;
               reply = {swapped[7:0], swapped[15:8]};
            end
            RUN_ECHO:  reply = $urandom_range(0, 1) ? probe : {probe[7:0], probe[15:8]};
            RUN_CONST: ;
            RUN_ZERO:  reply = 16'd0;
            default:   reply = 16'($urandom_range(0, 16'hFFFF));
         endcase
         // rare stray reply inside an otherwise clean run
         if ($urandom_range(0, 19) == 0) reply = 16'($urandom_range(0, 16'hFFFF));
         case (kind)
            RUN_BROKEN: ok = (k != bad_at);
            RUN_NOISE:  ok = ($urandom_range(0, 3) != 0);
            default:    ok = 1'b1;
         endcase
         fin = (kind == RUN_NOISE) ? ($urandom_range(0, 3) == 0) : (k == len - 1);
         send_beat(probe, reply, ok, fin);
      end
   endtask

   initial begin
      int n;
      req_bus.valid    = 1'b0;
      req_bus.probe_id = '0;
      req_bus.reply_id = '0;
      req_bus.reply_ok = 1'b0;
      req_bus.last     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-beat runs: zero reply, all-ones constant, bad reply
      send_beat(16'h1234, 16'h0000, 1'b1, 1'b1);
      send_beat(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);
      // echo run, one echo byte-swapped
      send_beat(16'h0010, 16'h0010, 1'b1, 1'b0);
      send_beat(16'h0020, 16'h2000, 1'b1, 1'b0);
      send_beat(16'h0030, 16'h0030, 1'b1, 1'b1);
      // native increments across the 16-bit wrap
      send_beat(16'hAAAA, 16'hFFFE, 1'b1, 1'b0);
      send_beat(16'h5555, 16'h0001, 1'b1, 1'b0);
      send_beat(16'h1111, 16'h0004, 1'b1, 1'b1);
      // increments in the high byte: byte-swapped order wins
      send_beat(16'h0001, 16'h0000, 1'b1, 1'b0);
      send_beat(16'h0002, 16'h0100, 1'b1, 1'b0);
      send_beat(16'h0003, 16'h0300, 1'b1, 1'b1);
      // echo breaks on a repeated reply, constant test skipped on that beat
      send_beat(16'h0000, 16'h4242, 1'b1, 1'b0);
      send_beat(16'h9999, 16'h4242, 1'b1, 1'b1);
      // multi-beat zero run
      send_beat(16'h0001, 16'h0000, 1'b1, 1'b0);
      send_beat(16'h0002, 16'h0000, 1'b1, 1'b1);
      // bad reply mid-run, later beats ignored
      send_beat(16'h0001, 16'h0005, 1'b1, 1'b0);
      send_beat(16'h0002, 16'h0006, 1'b0, 1'b0);
      send_beat(16'h0003, 16'h0009, 1'b1, 1'b1);
      // bad reply only on the last beat
      send_beat(16'hFFFF, 16'h0000, 1'b1, 1'b0);
      send_beat(16'h0000, 16'hFFFF, 1'b0, 1'b1);

      // back-pressure: receiver holds off while single-beat runs keep coming
      pressure_go = 1'b1;
      for (n = 0; n < 30; n++)
         send_beat(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                   1'b1, 1'b1);

      sent_beats = 0;
      while (sent_beats < ITEM_TARGET)
         random_run();
      req_bus.valid <= 1'b0;

      // drain outstanding verdicts, then allow for anything stray
      wait (verdicts_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/isc_pkg.sv
hdl/isc_req_if.sv
hdl/isc_rsp_if.sv
hdl/isc_track.sv
hdl/ipid_sequence_classifier.sv
verif/isc_class_checker.sv
verif/ipid_sequence_classifier_test.sv
